### hdl/bps_pkg.sv
package bps_pkg;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned DUTY_W = 7;

  localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd18;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TONE = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  typedef struct packed {
    logic             repeat_forever;
    logic [CNT_W-1:0] off_ticks;
    logic [CNT_W-1:0] on_ticks;
    logic [CNT_W-1:0] beep_count;
    logic [1:0]       req_type;
  } item_t;

  typedef struct packed {
    logic [1:0]        phase_now;
    logic [DUTY_W-1:0] drive_duty;
  } result_t;

endpackage

### hdl/beep_pattern_sequencer.sv
// Beep pattern sequencer.
// Slave stream: tuser carries the request kind (0 tick, 1 start, 2 stop, 3 ignored);
// tdata carries the start parameters. Each tick item stands for one millisecond
// of the pattern. Master stream: one result item per request with the duty now
// driven and the phase after the request.
// Configuration: cfg_valid/cfg_data write tone_duty (percent, above 100 drives
// 100); cfg_ready is always high. Write it only while no item is in flight.
// A request passes the input register, then the result register, before its
// result item is valid; a full result buffer can hold it in the input register.
// Throughput: one item per cycle while the result buffer has room; the state
// update decrements and compares the 16-bit tick and beep counters per item.
// Stall: a two-entry result buffer lets the block keep taking requests while a
// result waits; once both entries and the input register are full s_axis_tready
// drops and requests hold on the bus, nothing is dropped.
// Reset: idle, counters cleared, tone_duty back to 18, both streams empty.
module beep_pattern_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // beep_count[15:0], on_ticks[31:16], off_ticks[47:32], repeat_forever[48], zero pad
  input  logic [55:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_duty[6:0], phase_now[8:7], zero pad
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  import bps_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    step;
  logic    push_ready;
  result_t result;
  result_t out_data;

  assign in_item.req_type       = s_axis_tuser;
  assign in_item.beep_count     = s_axis_tdata[15:0];
  assign in_item.on_ticks       = s_axis_tdata[31:16];
  assign in_item.off_ticks      = s_axis_tdata[47:32];
  assign in_item.repeat_forever = s_axis_tdata[48];

  assign step      = held_valid && push_ready;
  assign cfg_ready = 1'b1;

  bps_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_take  (step),
    .held_item  (held_item)
  );

  bps_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_duty (cfg_data),
    .step     (step),
    .item     (held_item),
    .result   (result)
  );

  bps_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_ready (push_ready),
    .push_data  (result),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_data)
  );

  assign m_axis_tdata = {7'd0, out_data.phase_now, out_data.drive_duty};

endmodule

### hdl/bps_in_reg.sv
module bps_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bps_pkg::item_t in_item,
  output logic           held_valid,
  input  logic           held_take,
  output bps_pkg::item_t held_item
);
  import bps_pkg::*;

  logic  valid;
  item_t item;

  assign in_ready   = !valid || held_take;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### hdl/bps_core.sv
module bps_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bps_pkg::DUTY_W-1:0] cfg_duty,
  input  logic                      step,
  input  bps_pkg::item_t            item,
  output bps_pkg::result_t          result
);
  import bps_pkg::*;

  logic [DUTY_W-1:0] tone_duty;
  phase_t            phase_reg, phase_next;
  logic [CNT_W-1:0]  ticks_left, ticks_left_next;
  logic [CNT_W-1:0]  beeps_remaining, beeps_remaining_next;
  logic              forever_flag, forever_flag_next;
  logic [CNT_W-1:0]  tone_len, tone_len_next;
  logic [CNT_W-1:0]  gap_len, gap_len_next;
  logic [CNT_W-1:0]  ticks_dec;
  logic [CNT_W-1:0]  beeps_dec;
  logic [DUTY_W-1:0] duty_sat;

  assign ticks_dec = (ticks_left != '0) ? ticks_left - 1'b1 : '0;
  assign beeps_dec = (beeps_remaining != '0) ? beeps_remaining - 1'b1 : '0;

  always_comb begin
    phase_next           = phase_reg;
    ticks_left_next      = ticks_left;
    beeps_remaining_next = beeps_remaining;
    forever_flag_next    = forever_flag;
    tone_len_next        = tone_len;
    gap_len_next         = gap_len;
    unique case (req_t'(item.req_type))
      REQ_TICK: begin
        if (phase_reg != PH_IDLE) begin
          ticks_left_next = ticks_dec;
          if (ticks_dec == '0) begin
            if (phase_reg == PH_TONE) begin
              if (!forever_flag) begin
                beeps_remaining_next = beeps_dec;
              end
              if (!forever_flag && beeps_dec == '0) begin
                phase_next = PH_IDLE;
              end else if (gap_len == '0) begin
                // no gap: restart the tone on this tick
                phase_next      = PH_TONE;
                ticks_left_next = tone_len;
              end else begin
                phase_next      = PH_GAP;
                ticks_left_next = gap_len;
              end
            end else begin
              phase_next      = PH_TONE;
              ticks_left_next = tone_len;
            end
          end
        end
      end
      REQ_START: begin
        if (item.on_ticks == '0 || (!item.repeat_forever && item.beep_count == '0)) begin
          phase_next           = PH_IDLE;
          ticks_left_next      = '0;
          beeps_remaining_next = '0;
          forever_flag_next    = 1'b0;
        end else begin
          tone_len_next        = item.on_ticks;
          gap_len_next         = item.off_ticks;
          forever_flag_next    = item.repeat_forever;
          beeps_remaining_next = item.repeat_forever ? '0 : item.beep_count;
          phase_next           = PH_TONE;
          ticks_left_next      = item.on_ticks;
        end
      end
      REQ_STOP: begin
        phase_next           = PH_IDLE;
        ticks_left_next      = '0;
        beeps_remaining_next = '0;
        forever_flag_next    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign duty_sat = (tone_duty > DUTY_MAX) ? DUTY_MAX : tone_duty;

  always_comb begin
    result.phase_now  = phase_next;
    result.drive_duty = (phase_next == PH_TONE) ? duty_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_duty       <= DUTY_RESET;
      phase_reg       <= PH_IDLE;
      ticks_left      <= '0;
      beeps_remaining <= '0;
      forever_flag    <= 1'b0;
      tone_len        <= '0;
      gap_len         <= '0;
    end else begin
      if (cfg_we) begin
        tone_duty <= cfg_duty;
      end
      if (step) begin
        phase_reg       <= phase_next;
        ticks_left      <= ticks_left_next;
        beeps_remaining <= beeps_remaining_next;
        forever_flag    <= forever_flag_next;
        tone_len        <= tone_len_next;
        gap_len         <= gap_len_next;
      end
    end
  end

endmodule

### hdl/bps_out_buf.sv
module bps_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  bps_pkg::result_t push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bps_pkg::result_t out_data
);
  import bps_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign push_ready = !skid_valid;
  assign pop        = main_valid && out_ready;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      // skid holds the newer item; push is blocked while it is full
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push && !skid_valid) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push && !skid_valid) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule
